FILE: src/bidmap_pkg.sv
// Shared types, codes and defaults for the bidirectional id map.
package bidmap_pkg;

    localparam int NUM_W       = 11;
    localparam int CMD_W       = 2;
    localparam int ERR_W       = 3;
    localparam int ENTRIES_DEF = 1024;

    typedef logic signed [NUM_W-1:0] num_t;
    typedef logic [CMD_W-1:0]        cmd_t;
    typedef logic [ERR_W-1:0]        err_t;

    localparam num_t EMPTY = '1;

    localparam cmd_t CMD_BIND       = 2'd0;
    localparam cmd_t CMD_UNBIND     = 2'd1;
    localparam cmd_t CMD_FIND_LOGIC = 2'd2;
    localparam cmd_t CMD_FIND_NET   = 2'd3;

    localparam err_t ERR_NONE       = 3'd0;
    localparam err_t ERR_BAD_NET    = 3'd1;
    localparam err_t ERR_BAD_ID     = 3'd2;
    localparam err_t ERR_NET_BOUND  = 3'd3;
    localparam err_t ERR_ID_BOUND   = 3'd4;
    localparam err_t ERR_MISMATCH   = 3'd5;

endpackage

FILE: src/bidmap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bidmap_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-edge write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/bidirectional_id_map_top.sv
// Top level of the bidirectional connection number / logical id map.
//
//  channel   dir  tdata                                       tuser
//  s_ axis   in   [10:0] net_number, [21:11] logical_id       [1:0] cmd
//  m_ axis   out  [0] ok, [11:1] partner, [14:12] error_code  -
//
// One transfer in per cycle unless the sweep or a stalled m_ side holds it: the table
// read is registered with the command; the check and table write-back follow alongside
// the output register. After reset both tables are swept empty, one entry per cycle, with
// s_tready low. A stalled m_ side holds the item in the check stage and then s_tready.
module bidirectional_id_map_top #(
    parameter int ENTRIES = bidmap_pkg::ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // net_number, logical_id, zero pad
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ok, partner, error_code, zero pad
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int NW = bidmap_pkg::NUM_W;

    typedef logic [AW-1:0] addr_t;

    function automatic logic in_range(input bidmap_pkg::num_t n);
        logic [31:0] ext;
        ext = {{(32-NW){1'b0}}, n};
        return !n[NW-1] && (ext < 32'(ENTRIES));
    endfunction

    function automatic addr_t to_addr(input bidmap_pkg::num_t n);
        logic [AW+NW-1:0] ext;
        ext = {{AW{1'b0}}, n};
        return ext[AW-1:0];
    endfunction

    bidmap_pkg::num_t in_net, in_id;
    logic             s_accept, advance;

    // clearing sweep
    logic  clr_busy_reg;
    addr_t clr_cnt_reg;

    // check stage
    logic              p_valid_reg;
    bidmap_pkg::cmd_t  p_cmd_reg;
    bidmap_pkg::num_t  p_net_reg, p_id_reg;

    // last write to each table, covers the read that raced it
    logic             lw_n2l_valid_reg, lw_l2n_valid_reg;
    addr_t            lw_n2l_addr_reg, lw_l2n_addr_reg;
    bidmap_pkg::num_t lw_n2l_data_reg, lw_l2n_data_reg;

    // output register
    logic             m_valid_reg, m_ok_reg;
    bidmap_pkg::num_t m_partner_reg;
    bidmap_pkg::err_t m_err_reg;

    logic [NW-1:0]    n2l_rd, l2n_rd;
    bidmap_pkg::num_t n2l_val, l2n_val, find_logical, find_net;
    bidmap_pkg::num_t net_u, id_u;
    addr_t            net_addr, id_addr;
    logic             net_in, id_in;

    logic             ok_next;
    bidmap_pkg::num_t partner_next;
    bidmap_pkg::err_t err_next;
    logic             n2l_we, l2n_we;
    addr_t            n2l_wa, l2n_wa;
    bidmap_pkg::num_t n2l_wd, l2n_wd;

    logic             ram_n2l_we, ram_l2n_we;
    addr_t            ram_n2l_wa, ram_l2n_wa;
    bidmap_pkg::num_t ram_n2l_wd, ram_l2n_wd;

    assign in_net = s_tdata[10:0];
    assign in_id  = s_tdata[21:11];

    assign advance  = p_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!p_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;

    assign net_addr = to_addr(p_net_reg);
    assign id_addr  = to_addr(p_id_reg);
    assign net_in   = in_range(p_net_reg);
    assign id_in    = in_range(p_id_reg);

    assign n2l_val = (lw_n2l_valid_reg && lw_n2l_addr_reg == net_addr) ? lw_n2l_data_reg
                                                                       : n2l_rd;
    assign l2n_val = (lw_l2n_valid_reg && lw_l2n_addr_reg == id_addr) ? lw_l2n_data_reg
                                                                      : l2n_rd;
    assign find_logical = net_in ? n2l_val : bidmap_pkg::EMPTY;
    assign find_net     = id_in  ? l2n_val : bidmap_pkg::EMPTY;

    always_comb begin
        ok_next      = 1'b1;
        partner_next = bidmap_pkg::EMPTY;
        err_next     = bidmap_pkg::ERR_NONE;
        n2l_we       = 1'b0;
        l2n_we       = 1'b0;
        n2l_wa       = net_addr;
        l2n_wa       = id_addr;
        n2l_wd       = bidmap_pkg::EMPTY;
        l2n_wd       = bidmap_pkg::EMPTY;
        net_u        = p_net_reg;
        id_u         = p_id_reg;
        case (p_cmd_reg)
            bidmap_pkg::CMD_BIND: begin
                if (!net_in) begin
                    err_next = bidmap_pkg::ERR_BAD_NET;
                end else if (!id_in) begin
                    err_next = bidmap_pkg::ERR_BAD_ID;
                end else if (find_logical != bidmap_pkg::EMPTY) begin
                    err_next = bidmap_pkg::ERR_NET_BOUND;
                end else if (find_net != bidmap_pkg::EMPTY) begin
                    err_next = bidmap_pkg::ERR_ID_BOUND;
                end
                if (err_next != bidmap_pkg::ERR_NONE) begin
                    ok_next = 1'b0;
                end else begin
                    n2l_we = 1'b1;
                    l2n_we = 1'b1;
                    n2l_wd = p_id_reg;
                    l2n_wd = p_net_reg;
                end
            end
            bidmap_pkg::CMD_UNBIND: begin
                if (p_net_reg == bidmap_pkg::EMPTY) begin
                    net_u = find_net;
                end else if (p_id_reg == bidmap_pkg::EMPTY) begin
                    id_u = find_logical;
                end else if (find_net != p_net_reg) begin
                    ok_next  = 1'b0;
                    err_next = bidmap_pkg::ERR_MISMATCH;
                end
                if (ok_next) begin
                    n2l_we = in_range(net_u);
                    l2n_we = in_range(id_u);
                    n2l_wa = to_addr(net_u);
                    l2n_wa = to_addr(id_u);
                end
            end
            bidmap_pkg::CMD_FIND_LOGIC: begin
                partner_next = find_logical;
            end
            bidmap_pkg::CMD_FIND_NET: begin
                partner_next = find_net;
            end
            default: begin
                partner_next = bidmap_pkg::EMPTY;
            end
        endcase
    end

    // the sweep owns the write ports until it finishes
    assign ram_n2l_we = clr_busy_reg || (advance && n2l_we);
    assign ram_l2n_we = clr_busy_reg || (advance && l2n_we);
    assign ram_n2l_wa = clr_busy_reg ? clr_cnt_reg : n2l_wa;
    assign ram_l2n_wa = clr_busy_reg ? clr_cnt_reg : l2n_wa;
    assign ram_n2l_wd = clr_busy_reg ? bidmap_pkg::EMPTY : n2l_wd;
    assign ram_l2n_wd = clr_busy_reg ? bidmap_pkg::EMPTY : l2n_wd;

    bidmap_ram #(
        .WIDTH (NW),
        .DEPTH (ENTRIES)
    ) u_n2l_ram (
        .aclk  (aclk),
        .we    (ram_n2l_we),
        .waddr (ram_n2l_wa),
        .wdata (ram_n2l_wd),
        .re    (s_accept),
        .raddr (to_addr(in_net)),
        .rdata (n2l_rd)
    );

    bidmap_ram #(
        .WIDTH (NW),
        .DEPTH (ENTRIES)
    ) u_l2n_ram (
        .aclk  (aclk),
        .we    (ram_l2n_we),
        .waddr (ram_l2n_wa),
        .wdata (ram_l2n_wd),
        .re    (s_accept),
        .raddr (to_addr(in_id)),
        .rdata (l2n_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg     <= 1'b1;
            clr_cnt_reg      <= '0;
            p_valid_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            lw_n2l_valid_reg <= 1'b0;
            lw_l2n_valid_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_cnt_reg <= clr_cnt_reg + addr_t'(1);
                if (clr_cnt_reg == AW'(ENTRIES - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (s_accept) begin
                p_valid_reg <= 1'b1;
            end else if (advance) begin
                p_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (advance && n2l_we) begin
                lw_n2l_valid_reg <= 1'b1;
            end
            if (advance && l2n_we) begin
                lw_l2n_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_cmd_reg <= s_tuser;
            p_net_reg <= in_net;
            p_id_reg  <= in_id;
        end
        if (advance) begin
            m_ok_reg      <= ok_next;
            m_partner_reg <= partner_next;
            m_err_reg     <= err_next;
            if (n2l_we) begin
                lw_n2l_addr_reg <= n2l_wa;
                lw_n2l_data_reg <= n2l_wd;
            end
            if (l2n_we) begin
                lw_l2n_addr_reg <= l2n_wa;
                lw_l2n_data_reg <= l2n_wd;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_err_reg, m_partner_reg, m_ok_reg};

endmodule

FILE: sim/bidmap_checker.sv
// Channel monitor for the bidirectional id map: predicts each result and compares.
`timescale 1ns / 1ps

module bidmap_checker #(
    parameter int ENTRIES = bidmap_pkg::ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // net_number, logical_id, zero pad
    input  logic [1:0]  s_tuser,   // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // ok, partner, error_code, zero pad
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic             ok;
        bidmap_pkg::num_t partner;
        bidmap_pkg::err_t err;
    } map_result_t;

    map_result_t      due_results[$];
    bidmap_pkg::num_t id_of_net [ENTRIES];
    bidmap_pkg::num_t net_of_id [ENTRIES];
    bidmap_pkg::err_t last_err;
    int               n_bad;
    int               n_seen;

    function automatic bit in_span(bidmap_pkg::num_t v);
        return (v >= 0) && (v < ENTRIES);
    endfunction

    function automatic bidmap_pkg::num_t id_for(bidmap_pkg::num_t n);
        return in_span(n) ? id_of_net[n] : bidmap_pkg::EMPTY;
    endfunction

    function automatic bidmap_pkg::num_t net_for(bidmap_pkg::num_t l);
        return in_span(l) ? net_of_id[l] : bidmap_pkg::EMPTY;
    endfunction

    // Updates the shadow tables and returns the result the block owes for this command.
    function automatic map_result_t apply_command(bidmap_pkg::cmd_t c, bidmap_pkg::num_t n,
                                                  bidmap_pkg::num_t l);
        map_result_t r;
        bit          clash;
        r.ok      = 1'b1;
        r.partner = bidmap_pkg::EMPTY;
        r.err     = bidmap_pkg::ERR_NONE;
        clash     = 1'b0;
        case (c)
            bidmap_pkg::CMD_BIND: begin
                if (!in_span(n))
                    r.err = bidmap_pkg::ERR_BAD_NET;
                else if (!in_span(l))
                    r.err = bidmap_pkg::ERR_BAD_ID;
                else if (id_of_net[n] != bidmap_pkg::EMPTY)
                    r.err = bidmap_pkg::ERR_NET_BOUND;
                else if (net_of_id[l] != bidmap_pkg::EMPTY)
                    r.err = bidmap_pkg::ERR_ID_BOUND;
                if (r.err != bidmap_pkg::ERR_NONE) begin
                    r.ok     = 1'b0;
                    last_err = r.err;
                end else begin
                    id_of_net[n] = l;
                    net_of_id[l] = n;
                end
            end
            bidmap_pkg::CMD_UNBIND: begin
                // an empty side is filled in from the other side's table
                if (n == bidmap_pkg::EMPTY)
                    n = net_for(l);
                else if (l == bidmap_pkg::EMPTY)
                    l = id_for(n);
                else if (net_for(l) != n)
                    clash = 1'b1;
                if (clash) begin
                    r.ok  = 1'b0;
                    r.err = bidmap_pkg::ERR_MISMATCH;
                end else begin
                    if (in_span(n))
                        id_of_net[n] = bidmap_pkg::EMPTY;
                    if (in_span(l))
                        net_of_id[l] = bidmap_pkg::EMPTY;
                end
            end
            bidmap_pkg::CMD_FIND_LOGIC: r.partner = id_for(n);
            default:                    r.partner = net_for(l);
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        map_result_t got;
        map_result_t want;
        map_result_t owed;
        if (!aresetn) begin
            for (int i = 0; i < ENTRIES; i++) begin
                id_of_net[i] = bidmap_pkg::EMPTY;
                net_of_id[i] = bidmap_pkg::EMPTY;
            end
            last_err = bidmap_pkg::ERR_NONE;
            due_results.delete();
            n_bad  = 0;
            n_seen = 0;
        end else begin
            // results first: nothing accepted at this edge can already be due
            if (m_tvalid && m_tready) begin
                got.ok      = m_tdata[0];
                got.partner = m_tdata[11:1];
                got.err     = m_tdata[14:12];
                n_seen++;
                if (due_results.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("result %0d unexpected: ok=%0b partner=%0d err=%0d",
                                 n_seen, got.ok, got.partner, got.err);
                end else begin
                    want = due_results.pop_front();
                    if (got.ok !== want.ok || got.partner !== want.partner
                            || got.err !== want.err) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("result %0d: expected ok=%0b partner=%0d err=%0d",
                                     n_seen, want.ok, want.partner, want.err);
                            $display("    got ok=%0b partner=%0d err=%0d",
                                     got.ok, got.partner, got.err);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                owed        = apply_command(s_tuser, s_tdata[10:0], s_tdata[21:11]);
                due_results = {due_results, owed};
            end
        end
        mismatches  <= n_bad;
        outstanding <= due_results.size();
    end

endmodule

FILE: sim/tb_bidirectional_id_map_top.sv
// Testbench top for the bidirectional id map: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_bidirectional_id_map_top;

    localparam int RUN_ITEMS   = 1525;
    localparam int STALL_LIMIT = 5000;   // covers the table sweep after reset

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int mismatches;
    int outstanding;
    int n_sent       = 0;
    int quiet_cycles = 0;
    bit no_idle      = 1'b0;

    bidirectional_id_map_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bidmap_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 22);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("bidirectional_id_map_top: mismatch");
            $finish;
        end
    end

    // One transfer on the s_ side; returns at the edge where it is taken.
    task automatic issue_command(input bidmap_pkg::cmd_t c, input bidmap_pkg::num_t n,
                                 input bidmap_pkg::num_t l);
        while (!no_idle && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {2'b00, l, n};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        n_sent++;
    endtask

    // Mostly a small key pool so binds collide, plus the top keys, empty and noise.
    function automatic bidmap_pkg::num_t pick_num();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return bidmap_pkg::num_t'($urandom_range(15));
        else if (r < 78)
            return bidmap_pkg::num_t'(1022 + $urandom_range(1));
        else if (r < 86)
            return bidmap_pkg::EMPTY;
        else
            return bidmap_pkg::num_t'($urandom_range(2047));
    endfunction

    initial begin
        int               pick;
        bidmap_pkg::num_t a;
        bidmap_pkg::num_t b;
        bidmap_pkg::cmd_t c;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        issue_command(bidmap_pkg::CMD_FIND_LOGIC, 11'sd0, bidmap_pkg::EMPTY);
        issue_command(bidmap_pkg::CMD_BIND, 11'sd0, 11'sd1023);
        issue_command(bidmap_pkg::CMD_BIND, 11'sd1023, 11'sd0);
        issue_command(bidmap_pkg::CMD_FIND_LOGIC, 11'sd0, bidmap_pkg::EMPTY);
        issue_command(bidmap_pkg::CMD_FIND_NET, bidmap_pkg::EMPTY, 11'sd0);
        issue_command(bidmap_pkg::CMD_BIND, 11'sd0, 11'sd5);          // connection taken
        issue_command(bidmap_pkg::CMD_BIND, 11'sd5, 11'sd1023);       // id taken
        issue_command(bidmap_pkg::CMD_BIND, bidmap_pkg::EMPTY, 11'sd5);
        issue_command(bidmap_pkg::CMD_BIND, 11'sd5, -11'sd1024);
        issue_command(bidmap_pkg::CMD_BIND, -11'sd1024, bidmap_pkg::EMPTY); // bad connection wins
        issue_command(bidmap_pkg::CMD_FIND_LOGIC, bidmap_pkg::EMPTY, 11'sd3);
        issue_command(bidmap_pkg::CMD_FIND_NET, 11'sd3, -11'sd1024);
        issue_command(bidmap_pkg::CMD_UNBIND, 11'sd0, 11'sd0);        // sides disagree
        issue_command(bidmap_pkg::CMD_UNBIND, bidmap_pkg::EMPTY, 11'sd1023);
        issue_command(bidmap_pkg::CMD_FIND_LOGIC, 11'sd0, bidmap_pkg::EMPTY);
        issue_command(bidmap_pkg::CMD_UNBIND, 11'sd1023, bidmap_pkg::EMPTY);
        issue_command(bidmap_pkg::CMD_FIND_NET, bidmap_pkg::EMPTY, 11'sd0);
        issue_command(bidmap_pkg::CMD_BIND, 11'sd7, 11'sd9);
        issue_command(bidmap_pkg::CMD_UNBIND, 11'sd7, 11'sd9);
        issue_command(bidmap_pkg::CMD_UNBIND, bidmap_pkg::EMPTY, bidmap_pkg::EMPTY);
        issue_command(bidmap_pkg::CMD_UNBIND, -11'sd5, bidmap_pkg::EMPTY);
        issue_command(bidmap_pkg::CMD_UNBIND, bidmap_pkg::EMPTY, -11'sd300);
        issue_command(bidmap_pkg::CMD_UNBIND, 11'sd3, -11'sd7);
        issue_command(bidmap_pkg::CMD_BIND, 11'sd1023, 11'sd1023);
        issue_command(bidmap_pkg::CMD_UNBIND, -11'sd2, 11'sd1023);

        while (n_sent < RUN_ITEMS) begin
            no_idle <= (n_sent >= 700) && (n_sent < 1000);
            pick = $urandom_range(99);
            if (pick < 20) begin
                // bind, look up and release one pair
                a = bidmap_pkg::num_t'($urandom_range(15));
                b = bidmap_pkg::num_t'($urandom_range(15));
                issue_command(bidmap_pkg::CMD_BIND, a, b);
                issue_command(bidmap_pkg::CMD_FIND_NET, pick_num(), b);
                case ($urandom_range(2))
                    0:       issue_command(bidmap_pkg::CMD_UNBIND, a, b);
                    1:       issue_command(bidmap_pkg::CMD_UNBIND, bidmap_pkg::EMPTY, b);
                    default: issue_command(bidmap_pkg::CMD_UNBIND, a, bidmap_pkg::EMPTY);
                endcase
            end else begin
                c = bidmap_pkg::cmd_t'($urandom_range(3));
                a = pick_num();
                b = pick_num();
                if (c == bidmap_pkg::CMD_UNBIND && $urandom_range(3) == 0)
                    a = bidmap_pkg::EMPTY;
                else if (c == bidmap_pkg::CMD_UNBIND && $urandom_range(3) == 0)
                    b = bidmap_pkg::EMPTY;
                issue_command(c, a, b);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("bidirectional_id_map_top: match");
        else
            $display("bidirectional_id_map_top: mismatch");
        $finish;
    end

endmodule
